FILE: sv/reol_pkg.sv
// Shared types and constants for the ring entry offset locator.
// No dependencies; used by reol_ctrl, reol_datapath and ring_entry_offset_locator.
`timescale 1ns / 1ps

package reol_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int FIELD_W    = 32;
    localparam int SLOT_IDX_W = 4;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 72;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_FIND = 1'b1;

    typedef struct packed {
        logic store_entry;
        logic find_load;
        logic rd_issue;
        logic walk_eval;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic walk_stop;
        logic out_free;
    } sts_t;

endpackage

FILE: sv/reol_ctrl.sv
// Sequencer for the ring entry offset locator: input handshake and find walk.
// Depends on reol_pkg; drives reol_datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module reol_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              kind,
    output reol_pkg::cmd_t    cmd,
    input  reol_pkg::sts_t    sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   ready_reg;
    logic   accept;

    assign s_tready = ready_reg;
    assign accept   = s_tvalid && ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (kind == reol_pkg::KIND_FIND))
                    begin
                        state_reg <= ST_PRIME;
                        ready_reg <= 1'b0;
                    end
                end
                ST_PRIME:
                begin
                    state_reg <= ST_WALK;
                end
                ST_WALK:
                begin
                    if (sts.walk_stop)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.store_entry = accept && (kind == reol_pkg::KIND_ADD);
                cmd.find_load   = accept && (kind == reol_pkg::KIND_FIND);
            end
            ST_PRIME:
            begin
                cmd.rd_issue = 1'b1;
            end
            ST_WALK:
            begin
                cmd.rd_issue  = 1'b1;
                cmd.walk_eval = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (state_reg == ST_IDLE))
        else $error("ready raised outside idle");

    a_find_primes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.find_load |=> (state_reg == ST_PRIME))
        else $error("find beat did not start a walk");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over an untaken beat");

endmodule

FILE: sv/reol_datapath.sv
// Datapath: slot memories, valid bits, ring pointers, walk offset and result register.
// Depends on reol_pkg; commanded by reol_ctrl.
`timescale 1ns / 1ps

module reol_datapath
#(
    parameter int SLOTS = reol_pkg::SLOTS_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  reol_pkg::cmd_t                       cmd,
    output reol_pkg::sts_t                       sts,
    input  logic [reol_pkg::FIELD_W-1:0]         entry_handle,
    input  logic [reol_pkg::FIELD_W-1:0]         entry_size,
    input  logic [reol_pkg::FIELD_W-1:0]         lookup_offset,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic                                 found,
    output logic [reol_pkg::SLOT_IDX_W-1:0]      slot_index,
    output logic [reol_pkg::FIELD_W-1:0]         found_handle,
    output logic [reol_pkg::FIELD_W-1:0]         byte_offset
);

    localparam int PTR_W = $clog2(SLOTS);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(SLOTS - 1);

    logic [reol_pkg::FIELD_W-1:0] handle_mem [SLOTS];
    logic [reol_pkg::FIELD_W-1:0] size_mem   [SLOTS];
    logic [SLOTS-1:0]             valid_reg;

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic             full_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;

    logic [PTR_W-1:0]             walk_addr_reg;
    logic [PTR_W-1:0]             walk_cnt_reg;
    logic [reol_pkg::FIELD_W-1:0] offset_reg;
    logic [reol_pkg::FIELD_W-1:0] rd_handle_reg;
    logic [reol_pkg::FIELD_W-1:0] rd_size_reg;
    logic [PTR_W-1:0]             rd_slot_reg;
    logic                         rd_valid_reg;

    logic                         res_found_reg;
    logic [PTR_W-1:0]             res_slot_reg;
    logic [reol_pkg::FIELD_W-1:0] res_handle_reg;
    logic [reol_pkg::FIELD_W-1:0] res_offset_reg;

    logic                         out_valid_reg;
    logic                         out_found_reg;
    logic [PTR_W-1:0]             out_slot_reg;
    logic [reol_pkg::FIELD_W-1:0] out_handle_reg;
    logic [reol_pkg::FIELD_W-1:0] out_offset_reg;

    logic hit;
    logic last;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] s);
        logic [PTR_W-1:0] n;
        n = (s == LAST_SLOT) ? '0 : s + 1'b1;
        return n;
    endfunction

    // slot memories
    always_ff @(posedge clk)
    begin
        if (cmd.store_entry)
        begin
            handle_mem[wr_ptr_reg] <= entry_handle;
            size_mem[wr_ptr_reg]   <= entry_size;
        end
        if (cmd.rd_issue)
        begin
            rd_handle_reg <= handle_mem[walk_addr_reg];
            rd_size_reg   <= size_mem[walk_addr_reg];
            rd_slot_reg   <= walk_addr_reg;
        end
    end

    always_comb
    begin
        rd_ptr_next = full_reg ? next_slot(rd_ptr_reg) : rd_ptr_reg;
        wr_ptr_next = next_slot(wr_ptr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            full_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.store_entry)
            begin
                valid_reg[wr_ptr_reg] <= 1'b1;
                wr_ptr_reg            <= wr_ptr_next;
                rd_ptr_reg            <= rd_ptr_next;
                if (wr_ptr_next == rd_ptr_next)
                    full_reg <= 1'b1;
            end
            if (cmd.rd_issue)
                rd_valid_reg <= valid_reg[walk_addr_reg];
        end
    end

    // walk: compare the fetched slot while the next one is read
    assign hit  = offset_reg < rd_size_reg;
    assign last = walk_cnt_reg == LAST_SLOT;

    always_ff @(posedge clk)
    begin
        if (cmd.find_load)
        begin
            walk_addr_reg <= rd_ptr_reg;
            walk_cnt_reg  <= '0;
            offset_reg    <= lookup_offset;
        end
        else
        begin
            if (cmd.rd_issue)
                walk_addr_reg <= next_slot(walk_addr_reg);
            if (cmd.walk_eval)
            begin
                if (!rd_valid_reg)
                begin
                    res_found_reg  <= 1'b0;
                    res_slot_reg   <= '0;
                    res_handle_reg <= '0;
                    res_offset_reg <= '0;
                end
                else if (hit)
                begin
                    res_found_reg  <= 1'b1;
                    res_slot_reg   <= rd_slot_reg;
                    res_handle_reg <= rd_handle_reg;
                    res_offset_reg <= offset_reg;
                end
                else
                begin
                    offset_reg     <= offset_reg - rd_size_reg;
                    walk_cnt_reg   <= walk_cnt_reg + 1'b1;
                    res_found_reg  <= 1'b0;
                    res_slot_reg   <= '0;
                    res_handle_reg <= '0;
                    res_offset_reg <= '0;
                end
            end
        end
    end

    assign sts.walk_stop = !rd_valid_reg || hit || last;
    assign sts.out_free  = !out_valid_reg || m_tready;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_found_reg  <= res_found_reg;
            out_slot_reg   <= res_slot_reg;
            out_handle_reg <= res_handle_reg;
            out_offset_reg <= res_offset_reg;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign found        = out_found_reg;
    assign slot_index   = reol_pkg::SLOT_IDX_W'(out_slot_reg);
    assign found_handle = out_handle_reg;
    assign byte_offset  = out_offset_reg;

    a_full_ptrs_meet: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("full ring with pointers apart");

    a_rd_moves_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_entry && !full_reg |=> (rd_ptr_reg == $past(rd_ptr_reg)))
        else $error("read pointer moved before the ring filled");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(out_found_reg)
            && $stable(out_slot_reg) && $stable(out_handle_reg)
            && $stable(out_offset_reg))
        else $error("result beat changed while waiting");

endmodule

FILE: sv/ring_entry_offset_locator.sv
// Top level of the ring entry offset locator: stream ports, controller and datapath.
// Depends on reol_pkg, reol_ctrl and reol_datapath.
`timescale 1ns / 1ps

// A ring of SLOTS entries (handle, byte size) that overwrites its oldest entry
// once full. An add beat (tuser = 0) is stored in the cycle it is taken and
// gives no result; adds may arrive every cycle while no find is in progress.
// A find beat (tuser = 1) walks from the oldest entry, one slot per cycle out
// of the slot memory, and returns one result beat: found, slot, handle and the
// byte offset inside that entry, or all zeros when not found. A find visiting
// n slots (1 to SLOTS) holds the input until its result is loaded. The result
// sits in an output register, so the next beat is taken while it waits.

module ring_entry_offset_locator
#(
    parameter int SLOTS = reol_pkg::SLOTS_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_handle, entry_size, lookup_offset
    input  logic [reol_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // found, slot_index, found_handle, byte_offset, zero pad
    output logic [reol_pkg::M_TDATA_W-1:0]  m_tdata
);

    reol_pkg::cmd_t cmd;
    reol_pkg::sts_t sts;

    logic                                found;
    logic [reol_pkg::SLOT_IDX_W-1:0]     slot_index;
    logic [reol_pkg::FIELD_W-1:0]        found_handle;
    logic [reol_pkg::FIELD_W-1:0]        byte_offset;

    reol_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

    reol_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .entry_handle  (s_tdata[31:0]),
        .entry_size    (s_tdata[63:32]),
        .lookup_offset (s_tdata[95:64]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .found         (found),
        .slot_index    (slot_index),
        .found_handle  (found_handle),
        .byte_offset   (byte_offset)
    );

    assign m_tdata = {3'b000, byte_offset, found_handle, slot_index, found};

endmodule

FILE: tb/sv/tb.sv
// Self-checking bench for ring_entry_offset_locator: add and find beats over the stream ports.
// Depends on reol_pkg and the DUT sources; a scoreboard class predicts each find result.
`timescale 1ns / 1ps

module tb;

    localparam int RING_SLOTS   = reol_pkg::SLOTS_DEFAULT;
    localparam int RANDOM_BEATS = 725;
    localparam int HOLD_START   = 1500;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic        found;
        logic [3:0]  slot;
        logic [31:0] handle;
        logic [31:0] offset;
    } locate_t;

    class locator_scoreboard;
        logic [31:0] handles [RING_SLOTS];
        logic [31:0] sizes [RING_SLOTS];
        bit          valid [RING_SLOTS];
        int          wr_ptr;
        int          rd_ptr;
        bit          full;
        locate_t     expected [$];
        int          errors;
        int          results_seen;

        task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
            $display("MISMATCH result %0d %s: expected %h got %h",
                     results_seen, what, want, got);
            errors++;
        endtask

        function int pending();
            return expected.size();
        endfunction

        function void note_beat(logic kind, logic [reol_pkg::S_TDATA_W-1:0] data);
            logic [31:0] off;
            locate_t     res;
            int          s;
            if (kind == reol_pkg::KIND_ADD)
            begin
                handles[wr_ptr] = data[31:0];
                sizes[wr_ptr]   = data[63:32];
                valid[wr_ptr]   = 1'b1;
                if (full)
                    rd_ptr = (rd_ptr + 1) % RING_SLOTS;
                wr_ptr = (wr_ptr + 1) % RING_SLOTS;
                if (wr_ptr == rd_ptr)
                    full = 1'b1;
            end
            else
            begin
                off = data[95:64];
                res = '0;
                for (int k = 0; k < RING_SLOTS; k++)
                begin
                    s = (rd_ptr + k) % RING_SLOTS;
                    if (!valid[s])
                        break;
                    if (off < sizes[s])
                    begin
                        res.found  = 1'b1;
                        res.slot   = s[3:0];
                        res.handle = handles[s];
                        res.offset = off;
                        break;
                    end
                    off -= sizes[s];
                end
                expected.push_back(res);
            end
        endfunction

        task check_beat(logic [reol_pkg::M_TDATA_W-1:0] data);
            locate_t want;
            if (expected.size() == 0)
            begin
                report_mismatch("unexpected beat", '0, data[31:0]);
            end
            else
            begin
                want = expected.pop_front();
                if (data[0] !== want.found)
                    report_mismatch("found", 32'(want.found), 32'(data[0]));
                if (data[4:1] !== want.slot)
                    report_mismatch("slot_index", 32'(want.slot), 32'(data[4:1]));
                if (data[36:5] !== want.handle)
                    report_mismatch("found_handle", want.handle, data[36:5]);
                if (data[68:37] !== want.offset)
                    report_mismatch("byte_offset", want.offset, data[68:37]);
            end
            results_seen++;
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [reol_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [reol_pkg::M_TDATA_W-1:0] m_tdata;

    locator_scoreboard sb;
    int burst_left;

    ring_entry_offset_locator #(.SLOTS(RING_SLOTS)) DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_beat(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata);
        end
    end

    task automatic send_beat(logic kind, logic [31:0] handle, logic [31:0] size,
                             logic [31:0] offset);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {offset, size, handle};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic put_entry(logic [31:0] handle, logic [31:0] size);
        send_beat(reol_pkg::KIND_ADD, handle, size, $urandom);
    endtask

    task automatic find_offset(logic [31:0] offset);
        send_beat(reol_pkg::KIND_FIND, $urandom, $urandom, offset);
    endtask

    // receiver: stall rate redrawn by the cycle counter, plus one long hold-off
    initial
    begin
        int cyc;
        int stall_pct;
        cyc = 0;
        stall_pct = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == HOLD_START)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (cyc % 64 == 0)
            begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [31:0] size;
        logic [31:0] offset;
        sb = new;
        burst_left = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= reol_pkg::KIND_ADD;
        s_tdata  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty ring, zero-size skip, extreme handles and sizes
        find_offset(32'h0);
        put_entry(32'h0, 32'h0);
        find_offset(32'h0);
        put_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_entry(32'hA5A5_5A5A, 32'h1);
        find_offset(32'h0);
        find_offset(32'hFFFF_FFFE);
        find_offset(32'hFFFF_FFFF);
        // fill the ring, then overwrite the two oldest entries
        for (int i = 0; i < 15; i++)
            put_entry($urandom, 32'h3);
        find_offset(32'd45);
        find_offset(32'd46);

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 9))
                    0:       size = 32'h0;
                    1:       size = $urandom;
                    default: size = $urandom_range(0, 24);
                endcase
                put_entry($urandom, size);
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:       offset = $urandom;
                    1:       offset = $urandom_range(0, 40);
                    default: offset = $urandom_range(0, 260);
                endcase
                find_offset(offset);
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
sv/reol_pkg.sv
sv/reol_ctrl.sv
sv/reol_datapath.sv
sv/ring_entry_offset_locator.sv
tb/sv/tb.sv
